[hw/rtl/mono_bitmap_color_expander_macros.svh]
// Assertion helpers for the bitmap color expander.
// Every macro samples on i_clk; the checker that uses them declares that port.
`ifndef MONO_BITMAP_COLOR_EXPANDER_MACROS_SVH
`define MONO_BITMAP_COLOR_EXPANDER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MBCE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mbce assertion failed");

// Next-cycle implication, disabled while reset is held.
`define MBCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mbce assertion failed");

// Next-cycle implication that is also checked through reset.
`define MBCE_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mbce assertion failed");

`endif

[hw/rtl/mbce_pkg.sv]
`timescale 1ns / 1ps
package mbce_pkg;

    // Field widths.
    localparam int COORD_BITS = 10;
    localparam int COLOR_BITS = 16;
    localparam int ADDR_BITS  = 20;
    localparam int BYTE_BITS  = 8;

    // Bit select within a page byte.
    localparam int SEL_BITS = 3;
    localparam logic [SEL_BITS-1:0] BIT_SEL_MASK = 3'h7;
    localparam int PAGE_BITS = COORD_BITS + 1 - SEL_BITS;

    // Address arithmetic widths.
    localparam int PROD_BITS = COORD_BITS + PAGE_BITS;
    localparam int SUM_BITS  = (PROD_BITS + 2 > ADDR_BITS) ? PROD_BITS + 2 : ADDR_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (COLOR_BITS > COORD_BITS) ? COLOR_BITS : COORD_BITS;

    // Queue depths.
    localparam int JOB_DEPTH      = 2;
    localparam int JOB_PTR_BITS   = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_COUNT_BITS = $clog2(JOB_DEPTH + 1);
    localparam int RES_DEPTH      = 2;
    localparam int RES_PTR_BITS   = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int RES_COUNT_BITS = $clog2(RES_DEPTH + 1);

    // Input commands.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_X_OFFSET      = 3'd1,
        CFG_Y_OFFSET      = 3'd2,
        CFG_WINDOW_WIDTH  = 3'd3,
        CFG_WINDOW_HEIGHT = 3'd4,
        CFG_FG_COLOR      = 3'd5,
        CFG_BG_COLOR      = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [COORD_BITS-1:0] image_width;
        logic [COORD_BITS-1:0] x_offset;
        logic [COORD_BITS-1:0] y_offset;
        logic [COORD_BITS-1:0] window_width;
        logic [COORD_BITS-1:0] window_height;
        logic [COLOR_BITS-1:0] fg_color;
        logic [COLOR_BITS-1:0] bg_color;
    } t_cfg;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic                  has_pixel;
        logic                  pixel_bit;
        logic                  fetch_valid;
        logic                  last_pixel;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } t_job;

    typedef struct packed {
        logic                  has_pixel;
        logic [COLOR_BITS-1:0] pixel_color;
        logic [ADDR_BITS-1:0]  fetch_address;
        logic                  last_pixel;
    } t_result;

endpackage

[hw/rtl/mbce_cfg_regs.sv]
`timescale 1ns / 1ps
module mbce_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbce_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mbce_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output mbce_pkg::t_cfg                      o_cfg
);
    import mbce_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    // Decode the register index; unused indexes are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_IMAGE_WIDTH:   n_cfg.image_width   = i_cfg_data[COORD_BITS-1:0];
                CFG_X_OFFSET:      n_cfg.x_offset      = i_cfg_data[COORD_BITS-1:0];
                CFG_Y_OFFSET:      n_cfg.y_offset      = i_cfg_data[COORD_BITS-1:0];
                CFG_WINDOW_WIDTH:  n_cfg.window_width  = i_cfg_data[COORD_BITS-1:0];
                CFG_WINDOW_HEIGHT: n_cfg.window_height = i_cfg_data[COORD_BITS-1:0];
                CFG_FG_COLOR:      n_cfg.fg_color      = i_cfg_data[COLOR_BITS-1:0];
                CFG_BG_COLOR:      n_cfg.bg_color      = i_cfg_data[COLOR_BITS-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width   <= '0;
            r_cfg.x_offset      <= '0;
            r_cfg.y_offset      <= '0;
            r_cfg.window_width  <= '0;
            r_cfg.window_height <= '0;
            r_cfg.fg_color      <= '1;
            r_cfg.bg_color      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/mbce_front.sv]
`timescale 1ns / 1ps
module mbce_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_command,
    input  logic [mbce_pkg::BYTE_BITS-1:0] i_source_byte,
    input  mbce_pkg::t_cfg                 i_cfg,
    output mbce_pkg::t_job                 o_job
);
    import mbce_pkg::*;

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic                  r_active;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;
    logic                  n_active;
    logic [COORD_BITS-1:0] row_inc;
    logic [COORD_BITS-1:0] col_inc;
    logic [SEL_BITS-1:0]   bit_sel;
    logic                  row_wrap;
    logic                  col_wrap;

    // Walk the window column by column, one row per pixel transfer.
    always_comb begin
        bit_sel  = SEL_BITS'(r_row + i_cfg.y_offset) & BIT_SEL_MASK;
        row_inc  = r_row + 1'b1;
        col_inc  = r_col + 1'b1;
        row_wrap = (row_inc == '0) || (row_inc >= i_cfg.window_height);
        col_wrap = (col_inc == '0) || (col_inc >= i_cfg.window_width);

        n_col    = r_col;
        n_row    = r_row;
        n_active = r_active;
        o_job    = '0;

        if (i_command == CMD_START) begin
            n_col = '0;
            n_row = '0;
            if ((i_cfg.window_width == '0) || (i_cfg.window_height == '0)) begin
                // An empty window finishes right away.
                n_active         = 1'b0;
                o_job.last_pixel = 1'b1;
            end else begin
                n_active          = 1'b1;
                o_job.fetch_valid = 1'b1;
            end
        end else if (r_active) begin
            o_job.has_pixel = 1'b1;
            o_job.pixel_bit = i_source_byte[bit_sel];
            if (row_wrap) begin
                n_row = '0;
                if (col_wrap) begin
                    n_col            = '0;
                    n_active         = 1'b0;
                    o_job.last_pixel = 1'b1;
                end else begin
                    n_col = col_inc;
                end
            end else begin
                n_row = row_inc;
            end
            o_job.fetch_valid = n_active;
        end
        o_job.col = n_col;
        o_job.row = n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
        end else if (i_accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_active <= n_active;
        end
    end

endmodule

[hw/rtl/mbce_job_fifo.sv]
`timescale 1ns / 1ps
module mbce_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  mbce_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output mbce_pkg::t_job o_job
);
    import mbce_pkg::*;

    t_job                      r_mem [JOB_DEPTH];
    logic [JOB_PTR_BITS-1:0]   r_wr_ptr;
    logic [JOB_PTR_BITS-1:0]   r_rd_ptr;
    logic [JOB_COUNT_BITS-1:0] r_count;
    logic                      do_wr;
    logic                      do_rd;

    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;
    assign o_full  = (r_count == JOB_COUNT_BITS'(JOB_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == JOB_PTR_BITS'(JOB_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == JOB_PTR_BITS'(JOB_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/mbce_back.sv]
`timescale 1ns / 1ps
module mbce_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mbce_pkg::t_cfg                  i_cfg,
    input  logic                            i_job_valid,
    input  mbce_pkg::t_job                  i_job,
    output logic                            o_job_take,
    input  logic                            i_pop,
    output logic                            o_empty,
    output mbce_pkg::t_result               o_result
);
    import mbce_pkg::*;

    t_result                   r_mem [RES_DEPTH];
    logic [RES_PTR_BITS-1:0]   r_wr_ptr;
    logic [RES_PTR_BITS-1:0]   r_rd_ptr;
    logic [RES_COUNT_BITS-1:0] r_count;
    logic                      do_rd;
    logic [COORD_BITS:0]       row_sum;
    logic [PAGE_BITS-1:0]      page;
    logic [PROD_BITS-1:0]      product;
    logic [SUM_BITS-1:0]       addr_sum;
    t_result                   result;

    // Color pick and source address of the next pixel.
    always_comb begin
        row_sum  = (COORD_BITS + 1)'(i_job.row) + (COORD_BITS + 1)'(i_cfg.y_offset);
        page     = row_sum[COORD_BITS:SEL_BITS];
        product  = PROD_BITS'(i_cfg.image_width) * PROD_BITS'(page);
        addr_sum = SUM_BITS'(product) + SUM_BITS'(i_job.col) + SUM_BITS'(i_cfg.x_offset);

        result.has_pixel     = i_job.has_pixel;
        result.last_pixel    = i_job.last_pixel;
        result.pixel_color   = '0;
        result.fetch_address = '0;
        if (i_job.has_pixel) begin
            result.pixel_color = i_job.pixel_bit ? i_cfg.fg_color : i_cfg.bg_color;
        end
        if (i_job.fetch_valid) begin
            result.fetch_address = addr_sum[ADDR_BITS-1:0];
        end
    end

    assign o_job_take = i_job_valid && (r_count != RES_COUNT_BITS'(RES_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_rd      = i_pop && !o_empty;
    assign o_result   = r_mem[r_rd_ptr];

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_mem[r_wr_ptr] <= result;
        end
    end

    // Result queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (o_job_take) begin
                r_wr_ptr <= (r_wr_ptr == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == RES_PTR_BITS'(RES_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (o_job_take && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !o_job_take) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/mono_bitmap_color_expander.sv]
`timescale 1ns / 1ps
// Each item passes through the job queue and then the result queue, both registered, and
// a full result queue stalls the job queue until the receiver pops a result.
// Throughput: 1 item per cycle while the result queue has room, set by the two-entry job
// queue and two-entry result queue, each of which drains one entry per cycle when not stalled.
// Reset (i_rst_n low at a clock edge) empties both queues, idles the draw counters and
// restores the registers to their defaults (colors: foreground all ones, background 0).
module mono_bitmap_color_expander (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_command,
    input  logic [mbce_pkg::BYTE_BITS-1:0]      i_source_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_has_pixel,
    output logic [mbce_pkg::COLOR_BITS-1:0]     o_pixel_color,
    output logic [mbce_pkg::ADDR_BITS-1:0]      o_fetch_address,
    output logic                                o_last_pixel,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbce_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [mbce_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import mbce_pkg::*;

    t_cfg    cfg;
    t_job    front_job;
    t_job    queued_job;
    t_result result;
    logic    accept;
    logic    job_valid;
    logic    job_take;

    assign accept = push && !full;

    // Register file.
    mbce_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Front end: window walk and pixel bit selection.
    mbce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_command),
        .i_source_byte (i_source_byte),
        .i_cfg         (cfg),
        .o_job         (front_job)
    );

    // Queue between the two halves.
    mbce_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_job   (front_job),
        .o_full  (full),
        .i_rd    (job_take),
        .o_valid (job_valid),
        .o_job   (queued_job)
    );

    // Back end: color and fetch address, then the result queue.
    mbce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (queued_job),
        .o_job_take  (job_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_has_pixel     = result.has_pixel;
    assign o_pixel_color   = result.pixel_color;
    assign o_fetch_address = result.fetch_address;
    assign o_last_pixel    = result.last_pixel;

endmodule

[hw/rtl/mbce_checker.sv]
`timescale 1ns / 1ps
`include "mono_bitmap_color_expander_macros.svh"
module mbce_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            push,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input logic                            o_has_pixel,
    input logic [mbce_pkg::COLOR_BITS-1:0] o_pixel_color,
    input logic [mbce_pkg::ADDR_BITS-1:0]  o_fetch_address,
    input logic                            o_last_pixel
);
    import mbce_pkg::*;

    // A waiting result holds until it is transferred.
    `MBCE_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_pixel_color) && $stable(o_fetch_address))

    // A result without a pixel carries no color.
    `MBCE_ASSERT_IMP(a_no_pixel_no_color, !empty && !o_has_pixel, o_pixel_color == '0)

    // The final result of a draw points at no further source byte.
    `MBCE_ASSERT_IMP(a_last_no_fetch, !empty && o_last_pixel, o_fetch_address == '0)

    // Reset leaves both queues empty.
    `MBCE_ASSERT_RST(a_reset_empty, !i_rst_n, empty && !full)

endmodule

bind mono_bitmap_color_expander mbce_checker u_mbce_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_has_pixel     (o_has_pixel),
    .o_pixel_color   (o_pixel_color),
    .o_fetch_address (o_fetch_address),
    .o_last_pixel    (o_last_pixel)
);

[sim/tb_mono_bitmap_color_expander.sv]
`timescale 1ns / 1ps
module tb_mono_bitmap_color_expander;
    import mbce_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SINK_HOLD     = 80;
    localparam int DRAW_CAP      = 40;

    typedef struct packed {
        logic                 command;
        logic [BYTE_BITS-1:0] source_byte;
    } t_pixel_item;

    // Block ports.
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push = 1'b0;
    logic                      full;
    logic                      command = CMD_START;
    logic [BYTE_BITS-1:0]      source_byte = '0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic                      has_pixel;
    logic [COLOR_BITS-1:0]     pixel_color;
    logic [ADDR_BITS-1:0]      fetch_address;
    logic                      last_pixel;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Handshake results sampled at the rising edge.
    logic push_fired = 1'b0;
    logic pop_fired = 1'b0;
    logic cfg_fired = 1'b0;

    // Sender and receiver state.
    t_pixel_item feed_items[$];
    t_pixel_item next_item;
    bit          offer_open = 1'b0;
    int          send_gap = 0;
    int          take_gap = 0;
    int          sink_hold_left = 0;
    bit          stall_request = 1'b0;
    bit          stall_served = 1'b0;
    bit          steady_flow = 1'b0;

    // Predicted block state and the results still to arrive.
    t_cfg                  settings;
    logic [COORD_BITS-1:0] draw_col;
    logic [COORD_BITS-1:0] draw_row;
    logic                  draw_busy;
    t_result               awaited_pixels[$];
    t_result               want;
    int                    error_count = 0;
    int                    cycle_count = 0;

    mono_bitmap_color_expander dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .push            (push),
        .full            (full),
        .i_command       (command),
        .i_source_byte   (source_byte),
        .empty           (empty),
        .pop             (pop),
        .o_has_pixel     (has_pixel),
        .o_pixel_color   (pixel_color),
        .o_fetch_address (fetch_address),
        .o_last_pixel    (last_pixel),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Byte address of the page byte that holds a given window pixel.
    function automatic logic [ADDR_BITS-1:0] source_address(logic [COORD_BITS-1:0] col,
                                                           logic [COORD_BITS-1:0] row);
        int unsigned page;
        int unsigned addr;
        page = (32'(row) + 32'(settings.y_offset)) >> 3;
        addr = 32'(settings.image_width) * page + 32'(col) + 32'(settings.x_offset);
        return addr[ADDR_BITS-1:0];
    endfunction

    // Works out the result of one item and advances the predicted draw.
    function automatic t_result expand_pixel(logic cmd, logic [BYTE_BITS-1:0] fetched);
        t_result               res;
        logic [SEL_BITS-1:0]   sel;
        res = '0;
        if (cmd == CMD_START) begin
            draw_col = '0;
            draw_row = '0;
            if (settings.window_width == '0 || settings.window_height == '0) begin
                draw_busy = 1'b0;
                res.last_pixel = 1'b1;
            end else begin
                draw_busy = 1'b1;
                res.fetch_address = source_address('0, '0);
            end
        end else if (draw_busy) begin
            sel = (draw_row[SEL_BITS-1:0] + settings.y_offset[SEL_BITS-1:0]) & BIT_SEL_MASK;
            res.has_pixel = 1'b1;
            res.pixel_color = fetched[sel] ? settings.fg_color : settings.bg_color;
            draw_row = draw_row + 1'b1;
            // A row counter at or past the height, shrunk or not, moves to the next column.
            if (draw_row == '0 || draw_row >= settings.window_height) begin
                draw_row = '0;
                draw_col = draw_col + 1'b1;
                if (draw_col == '0 || draw_col >= settings.window_width) begin
                    draw_col = '0;
                    draw_busy = 1'b0;
                    res.last_pixel = 1'b1;
                end
            end
            if (draw_busy) begin
                res.fetch_address = source_address(draw_col, draw_row);
            end
        end
        return res;
    endfunction

    // Rising edge: record every transfer, predict accepted items and check results.
    always @(posedge clk) begin
        if (!rst_n) begin
            push_fired <= 1'b0;
            pop_fired <= 1'b0;
            cfg_fired <= 1'b0;
            settings = '0;
            settings.fg_color = '1;
            draw_col = '0;
            draw_row = '0;
            draw_busy = 1'b0;
        end else begin
            push_fired <= push && !full;
            pop_fired <= pop && !empty;
            cfg_fired <= cfg_valid && cfg_ready;
            if (pop && !empty) begin
                if (awaited_pixels.size() == 0) begin
                    $error("result transfer with no expected result waiting");
                    error_count++;
                end else begin
                    want = awaited_pixels.pop_front();
                    if (has_pixel !== want.has_pixel) begin
                        $error("has_pixel: expected %0d, got %0d", want.has_pixel, has_pixel);
                        error_count++;
                    end
                    if (pixel_color !== want.pixel_color) begin
                        $error("pixel_color: expected %0h, got %0h",
                               want.pixel_color, pixel_color);
                        error_count++;
                    end
                    if (fetch_address !== want.fetch_address) begin
                        $error("fetch_address: expected %0h, got %0h",
                               want.fetch_address, fetch_address);
                        error_count++;
                    end
                    if (last_pixel !== want.last_pixel) begin
                        $error("last_pixel: expected %0d, got %0d", want.last_pixel, last_pixel);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (t_cfg_index'(cfg_index))
                    CFG_IMAGE_WIDTH:   settings.image_width = cfg_data[COORD_BITS-1:0];
                    CFG_X_OFFSET:      settings.x_offset = cfg_data[COORD_BITS-1:0];
                    CFG_Y_OFFSET:      settings.y_offset = cfg_data[COORD_BITS-1:0];
                    CFG_WINDOW_WIDTH:  settings.window_width = cfg_data[COORD_BITS-1:0];
                    CFG_WINDOW_HEIGHT: settings.window_height = cfg_data[COORD_BITS-1:0];
                    CFG_FG_COLOR:      settings.fg_color = cfg_data[COLOR_BITS-1:0];
                    CFG_BG_COLOR:      settings.bg_color = cfg_data[COLOR_BITS-1:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                awaited_pixels.push_back(expand_pixel(command, source_byte));
            end
        end
    end

    // Sender: holds each item until its transfer, then waits a random gap.
    always @(negedge clk) begin
        if (rst_n) begin
            if (push_fired) begin
                offer_open = 1'b0;
            end
            if (offer_open) begin
                // The block has not taken the item yet, so it stays on the ports.
            end else if (send_gap > 0) begin
                send_gap = send_gap - 1;
                push <= 1'b0;
            end else if (feed_items.size() > 0) begin
                next_item = feed_items.pop_front();
                push <= 1'b1;
                command <= next_item.command;
                source_byte <= next_item.source_byte;
                offer_open = 1'b1;
                send_gap = steady_flow ? 0 : $urandom_range(0, 3);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: random stall per result, plus one long hold to back up the block.
    always @(negedge clk) begin
        if (rst_n) begin
            if (pop_fired) begin
                take_gap = steady_flow ? 0 : $urandom_range(0, 3);
            end
            if (stall_request && !stall_served) begin
                sink_hold_left = SINK_HOLD;
                stall_served = 1'b1;
            end
            if (sink_hold_left > 0) begin
                sink_hold_left = sink_hold_left - 1;
                pop <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap = take_gap - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_mono_bitmap_color_expander: done, errors");
            $finish;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    function automatic void add_item(logic cmd, logic [BYTE_BITS-1:0] fetched);
        feed_items.push_back('{command: cmd, source_byte: fetched});
    endfunction

    // Coordinate register word with random junk above the used bits.
    function automatic logic [CFG_DATA_BITS-1:0] junk_word(logic [COORD_BITS-1:0] coord);
        logic [CFG_DATA_BITS-1:0] word;
        word = CFG_DATA_BITS'($urandom);
        word[COORD_BITS-1:0] = coord;
        return word;
    endfunction

    // Window extent: mostly small, sometimes empty or at the maximum.
    function automatic int pick_extent(int top);
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) begin
            return 0;
        end else if (roll == 1) begin
            return (1 << COORD_BITS) - 1;
        end
        return $urandom_range(1, top);
    endfunction

    task automatic write_register(t_cfg_index idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(negedge clk); while (!cfg_fired);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued item has been taken and every result has come back.
    task automatic wait_drained();
        do @(negedge clk);
        while (feed_items.size() != 0 || offer_open || awaited_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One random setting followed by draws with random page bytes.
    task automatic random_phase(int budget);
        int w;
        int h;
        int pixels;
        int roll;
        w = pick_extent(6);
        h = pick_extent(20);
        write_register(CFG_IMAGE_WIDTH, junk_word(COORD_BITS'($urandom)));
        write_register(CFG_X_OFFSET, junk_word(COORD_BITS'($urandom)));
        write_register(CFG_Y_OFFSET, junk_word(COORD_BITS'($urandom)));
        write_register(CFG_WINDOW_WIDTH, junk_word(COORD_BITS'(w)));
        write_register(CFG_WINDOW_HEIGHT, junk_word(COORD_BITS'(h)));
        write_register(CFG_FG_COLOR, CFG_DATA_BITS'($urandom));
        write_register(CFG_BG_COLOR, CFG_DATA_BITS'($urandom));
        while (budget > 0) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                // Stray item with random content.
                add_item(1'($urandom), BYTE_BITS'($urandom));
                budget = budget - 1;
            end else begin
                pixels = (w * h > DRAW_CAP) ? DRAW_CAP : w * h;
                // The last draw of a phase is trimmed to what is left of the budget.
                if (pixels > budget - 1) begin
                    pixels = budget - 1;
                end
                // A broken draw is cut short and abandoned by the next start.
                if (roll == 1 && pixels > 1) begin
                    pixels = $urandom_range(1, pixels - 1);
                end
                add_item(CMD_START, BYTE_BITS'($urandom));
                for (int i = 0; i < pixels; i++) begin
                    add_item(CMD_PIXEL, BYTE_BITS'($urandom));
                end
                budget = budget - 1 - pixels;
                if ($urandom_range(0, 3) == 0 && budget > 0) begin
                    add_item(CMD_PIXEL, BYTE_BITS'($urandom));
                    budget = budget - 1;
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default registers give an empty window; pixels around it find the block idle.
        add_item(CMD_PIXEL, 8'hFF);
        add_item(CMD_START, 8'h00);
        add_item(CMD_PIXEL, 8'h00);
        wait_drained();

        // Offsets and width at the maximum, colors swapped, a 2 by 3 window.
        write_register(CFG_IMAGE_WIDTH, CFG_DATA_BITS'((1 << COORD_BITS) - 1));
        write_register(CFG_X_OFFSET, CFG_DATA_BITS'((1 << COORD_BITS) - 1));
        write_register(CFG_Y_OFFSET, CFG_DATA_BITS'((1 << COORD_BITS) - 1));
        write_register(CFG_WINDOW_WIDTH, CFG_DATA_BITS'(2));
        write_register(CFG_WINDOW_HEIGHT, CFG_DATA_BITS'(3));
        write_register(CFG_FG_COLOR, '0);
        write_register(CFG_BG_COLOR, '1);
        add_item(CMD_START, 8'h00);
        add_item(CMD_PIXEL, 8'h00);
        add_item(CMD_PIXEL, 8'hFF);
        add_item(CMD_PIXEL, 8'h55);
        add_item(CMD_PIXEL, 8'hAA);
        add_item(CMD_PIXEL, 8'h80);
        add_item(CMD_PIXEL, 8'h01);
        add_item(CMD_PIXEL, 8'hFF);
        add_item(CMD_START, 8'h00);
        add_item(CMD_PIXEL, 8'h0F);
        add_item(CMD_PIXEL, 8'hF0);
        wait_drained();

        // Shrink the window under a running draw so it ends on the next pixel.
        write_register(CFG_WINDOW_HEIGHT, CFG_DATA_BITS'(1));
        write_register(CFG_WINDOW_WIDTH, CFG_DATA_BITS'(1));
        add_item(CMD_PIXEL, 8'h3C);
        add_item(CMD_START, 8'h00);
        add_item(CMD_PIXEL, 8'hC3);
        wait_drained();

        // Largest window at zero offsets; a start abandons the running draw.
        write_register(CFG_IMAGE_WIDTH, '0);
        write_register(CFG_X_OFFSET, '0);
        write_register(CFG_Y_OFFSET, '0);
        write_register(CFG_WINDOW_WIDTH, CFG_DATA_BITS'((1 << COORD_BITS) - 1));
        write_register(CFG_WINDOW_HEIGHT, CFG_DATA_BITS'((1 << COORD_BITS) - 1));
        write_register(CFG_FG_COLOR, '1);
        write_register(CFG_BG_COLOR, '0);
        add_item(CMD_START, 8'h00);
        add_item(CMD_PIXEL, 8'h01);
        add_item(CMD_PIXEL, 8'h02);
        add_item(CMD_PIXEL, 8'h04);
        add_item(CMD_PIXEL, 8'h08);
        add_item(CMD_START, 8'hFF);
        add_item(CMD_PIXEL, 8'hFE);
        wait_drained();

        // Zero height alone also makes an empty window.
        write_register(CFG_WINDOW_WIDTH, CFG_DATA_BITS'(5));
        write_register(CFG_WINDOW_HEIGHT, '0);
        add_item(CMD_START, 8'h00);
        wait_drained();

        // Random settings and draws; one phase backs up the block, two run without gaps.
        for (int phase = 0; phase < 12; phase++) begin
            steady_flow = (phase == 5 || phase == 9);
            if (phase == 2) begin
                stall_request = 1'b1;
            end
            random_phase(95);
        end

        if (error_count == 0) begin
            $display("tb_mono_bitmap_color_expander: done, clean");
        end else begin
            $display("tb_mono_bitmap_color_expander: done, errors");
        end
        $finish;
    end

endmodule
